FILE: hw/rtl/binary_min_heap_engine_top_assert.svh
// Assertion macros used by the heap engine checker.
`ifndef BINARY_MIN_HEAP_ENGINE_TOP_ASSERT_SVH
`define BINARY_MIN_HEAP_ENGINE_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define BMH_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("heap engine check failed");

// Next-cycle implication, disabled during reset.
`define BMH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("heap engine check failed");

`endif

FILE: hw/rtl/bmh_pkg.sv
// Types, constants and helpers for the binary min-heap engine.
`default_nettype none
package bmh_pkg;

    localparam int CAPACITY = 1024;
    localparam int KEY_W    = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CHILD_W  = CNT_W + 1;

    typedef enum logic [1:0] {
        FN_INSERT  = 2'd0,
        FN_POP     = 2'd1,
        FN_DELETE  = 2'd2,
        FN_REPLACE = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_BAD_POS  = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_REM,
        S_LAST,
        S_LAST2,
        S_DL,
        S_DR,
        S_DC,
        S_UP,
        S_UC,
        S_DONE
    } state_t;

    // Heap positions run from 1; the store is addressed from 0.
    function automatic logic [ADDR_W-1:0] pos_to_addr(input logic [CNT_W-1:0] p);
        logic [CNT_W-1:0] a;
        a = p - 1'b1;
        return a[ADDR_W-1:0];
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/binary_min_heap_engine_top.sv
// Binary min-heap engine: key store, sift sequencer and result registers.
//
//  Channel   Handshake          Payload
//  request   start / busy       func, key_value, position
//  result    done (one cycle)   status, removed_key, top_key, count
//
// A request is decoded in S_IDLE and ends with the result strobe in S_DONE.
// Sift-up steps through S_UP and S_UC a level and sift-down through S_DL, S_DR
// and S_DC, all on the single read port of the key store.
// Reset empties the heap at once; the store itself is not cleared.
// busy is high from acceptance until the end of the done cycle; the
// receiver cannot stall, so results are never held back.
`default_nettype none
module binary_min_heap_engine_top
    import bmh_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic [1:0]              func,
    input  wire logic signed [KEY_W-1:0] key_value,
    input  wire logic [CNT_W-1:0]        position,
    output logic                         done,
    output logic [1:0]                   status,
    output logic signed [KEY_W-1:0]      removed_key,
    output logic signed [KEY_W-1:0]      top_key,
    output logic [CNT_W-1:0]             count
);

    logic signed [KEY_W-1:0] mem [CAPACITY];
    logic signed [KEY_W-1:0] rd_data_reg;

    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [CNT_W-1:0]        p_reg, p_next;
    logic signed [KEY_W-1:0] cur_reg, cur_next;
    logic signed [KEY_W-1:0] lkey_reg, lkey_next;
    logic                    pick_l_reg, pick_l_next;
    logic                    has_right_reg, has_right_next;
    logic                    moved_reg, moved_next;
    status_t                 status_reg, status_next;
    logic signed [KEY_W-1:0] removed_reg, removed_next;
    logic signed [KEY_W-1:0] top_reg, top_next;

    logic                    we;
    logic [ADDR_W-1:0]       wa;
    logic signed [KEY_W-1:0] wd;
    logic [ADDR_W-1:0]       ra;

    logic [CHILD_W-1:0]      child_l;
    logic [CHILD_W-1:0]      child_r;
    logic [CHILD_W-1:0]      count_ext;
    logic [CNT_W-1:0]        del_pos;
    logic signed [KEY_W-1:0] best_key;
    logic                    pick_r;
    logic signed [KEY_W-1:0] cmp_a;
    logic signed [KEY_W-1:0] cmp_b;
    logic                    cmp_lt;

    assign child_l   = {p_reg, 1'b0};
    assign child_r   = child_l + 1'b1;
    assign count_ext = {1'b0, count_reg};
    assign best_key  = pick_l_reg ? lkey_reg : cur_reg;
    assign del_pos   = (func_t'(func) == FN_POP) ? CNT_W'(1) : position;

    // One signed comparator serves every state that compares keys.
    assign cmp_a  = (state_reg == S_UC) ? cur_reg : rd_data_reg;
    assign cmp_b  = (state_reg == S_DC) ? best_key :
                    ((state_reg == S_UC) ? rd_data_reg : cur_reg);
    assign cmp_lt = cmp_a < cmp_b;
    assign pick_r = has_right_reg && cmp_lt;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        rd_data_reg <= mem[ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            status_reg  <= ST_OK;
            removed_reg <= '0;
            moved_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            status_reg  <= status_next;
            removed_reg <= removed_next;
            moved_reg   <= moved_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg         <= p_next;
        cur_reg       <= cur_next;
        lkey_reg      <= lkey_next;
        pick_l_reg    <= pick_l_next;
        has_right_reg <= has_right_next;
        top_reg       <= top_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        p_next         = p_reg;
        cur_next       = cur_reg;
        lkey_next      = lkey_reg;
        pick_l_next    = pick_l_reg;
        has_right_next = has_right_reg;
        moved_next     = moved_reg;
        status_next    = status_reg;
        removed_next   = removed_reg;
        we             = 1'b0;
        wa             = pos_to_addr(p_reg);
        wd             = cur_reg;
        ra             = pos_to_addr(p_reg);

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    status_next  = ST_OK;
                    removed_next = '0;
                    moved_next   = 1'b0;
                    cur_next     = key_value;
                    case (func_t'(func))
                        FN_INSERT:
                        begin
                            if (count_reg >= CNT_W'(CAPACITY))
                            begin
                                status_next = ST_FULL;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                count_next = count_reg + 1'b1;
                                p_next     = count_reg + 1'b1;
                                state_next = S_UP;
                            end
                        end
                        FN_POP, FN_DELETE:
                        begin
                            p_next = del_pos;
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                                state_next  = S_DONE;
                            end
                            else if (del_pos == '0 || del_pos > count_reg)
                            begin
                                status_next = ST_BAD_POS;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                state_next = S_REM;
                            end
                        end
                        FN_REPLACE:
                        begin
                            p_next = position;
                            if (position == '0 || position > count_reg)
                            begin
                                status_next = ST_BAD_POS;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                state_next = S_DL;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_REM:
            begin
                state_next = S_LAST;
            end
            S_LAST:
            begin
                removed_next = rd_data_reg;
                ra           = pos_to_addr(count_reg);
                if (p_reg == count_reg)
                begin
                    // Removing the last key only shrinks the heap.
                    count_next = count_reg - 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_LAST2;
                end
            end
            S_LAST2:
            begin
                cur_next   = rd_data_reg;
                count_next = count_reg - 1'b1;
                state_next = S_DL;
            end
            S_DL:
            begin
                ra = pos_to_addr(child_l[CNT_W-1:0]);
                if (child_l > count_ext)
                begin
                    if (moved_reg)
                    begin
                        we         = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_UP;
                    end
                end
                else
                begin
                    state_next = S_DR;
                end
            end
            S_DR:
            begin
                lkey_next      = rd_data_reg;
                pick_l_next    = cmp_lt;
                has_right_next = child_r <= count_ext;
                ra             = pos_to_addr(child_r[CNT_W-1:0]);
                state_next     = S_DC;
            end
            S_DC:
            begin
                if (pick_r || pick_l_reg)
                begin
                    // The child moves up into the hole; the sifted key stays held.
                    we         = 1'b1;
                    wd         = pick_r ? rd_data_reg : lkey_reg;
                    p_next     = pick_r ? child_r[CNT_W-1:0] : child_l[CNT_W-1:0];
                    moved_next = 1'b1;
                    state_next = S_DL;
                end
                else if (moved_reg)
                begin
                    we         = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_UP;
                end
            end
            S_UP:
            begin
                ra = pos_to_addr(p_reg >> 1);
                if (p_reg == CNT_W'(1))
                begin
                    we         = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_UC;
                end
            end
            S_UC:
            begin
                we = 1'b1;
                if (cmp_lt)
                begin
                    wd         = rd_data_reg;
                    p_next     = p_reg >> 1;
                    state_next = S_UP;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // A shadow of the top entry saves a read when the result is formed.
    always_comb
    begin
        top_next = top_reg;
        if (we && wa == '0)
        begin
            top_next = wd;
        end
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = (state_reg == S_DONE);
    assign status      = status_reg;
    assign removed_key = removed_reg;
    assign top_key     = (count_reg != '0) ? top_reg : '0;
    assign count       = count_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/bmh_checker.sv
// Port-level checker for the heap engine, bound to the top level.
`default_nettype none
`include "binary_min_heap_engine_top_assert.svh"
module bmh_checker
    import bmh_pkg::*;
(
    input wire logic                    clk,
    input wire logic                    rst_n,
    input wire logic                    start,
    input wire logic                    busy,
    input wire logic                    done,
    input wire logic [1:0]              status,
    input wire logic signed [KEY_W-1:0] removed_key,
    input wire logic signed [KEY_W-1:0] top_key,
    input wire logic [CNT_W-1:0]        count
);

    // An accepted request always makes the engine busy in the next cycle.
    `BMH_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
    // The result strobe lasts exactly one cycle.
    `BMH_ASSERT_NEXT(a_done_single, clk, rst_n, done, !done && !busy)
    // A flagged request never reports a removed key.
    `BMH_ASSERT_NOW(a_flag_no_removed, clk, rst_n,
        done && (status != 2'(ST_OK)), removed_key == '0)
    // An empty heap reports a zero top key.
    `BMH_ASSERT_NOW(a_empty_top, clk, rst_n, done && (count == '0), top_key == '0)
    // A full flag means a full heap, with the count at the capacity.
    `BMH_ASSERT_NOW(a_count_bound, clk, rst_n,
        done && (status == 2'(ST_FULL)), count == CNT_W'(CAPACITY))

endmodule

bind binary_min_heap_engine_top bmh_checker u_bmh_checker (.*);
`default_nettype wire
